// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file dtd_checker.sv.
// Needs signals named clock and reset in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked outside reset.
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Implication checked at every edge, reset included.
`define ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/dtd_pkg.sv -----
// Types, character codes and helpers for the decimal text to double parser.
// No dependencies.
`timescale 1ns / 1ps

package dtd_pkg;

   typedef struct packed {
      logic [7:0] text_char;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [63:0] value_bits;
      logic        needs_fallback;
   } rsp_type;

   typedef struct packed {
      logic [52:0]        mant;
      logic signed [7:0]  expo;
   } rnd_type;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_PLUS  = 8'h2b;

   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_INT   = 2'd1;
   localparam logic [1:0] PH_FRAC  = 2'd2;
   localparam logic [1:0] PH_STOP  = 2'd3;

   localparam logic [4:0] INT_LIMIT = 5'd24;
   localparam logic [10:0] EXP_BIAS = 11'd1023;

   function automatic logic [26:0] pow10(input logic [3:0] n);
      logic [26:0] p;
      case (n)
         4'd1: p = 27'd10;
         4'd2: p = 27'd100;
         4'd3: p = 27'd1000;
         4'd4: p = 27'd10000;
         4'd5: p = 27'd100000;
         4'd6: p = 27'd1000000;
         4'd7: p = 27'd10000000;
         4'd8: p = 27'd100000000;
         default: p = 27'd1;
      endcase
      return p;
   endfunction

   // round to nearest even: w[55:3] kept, w[2] guard, w[1:0] sticky
   function automatic rnd_type round_ne(input logic [55:0] w, input logic signed [7:0] e);
      rnd_type r;
      logic inc;
      logic [53:0] m;
      inc = w[2] & (w[1] | w[0] | w[3]);
      m = {1'b0, w[55:3]} + {53'd0, inc};
      if (m[53]) begin
         r.mant = m[53:1];
         r.expo = e + 8'sd1;
      end else begin
         r.mant = m[52:0];
         r.expo = e;
      end
      return r;
   endfunction

endpackage

// ----- hdl/decimal_text_to_double.sv -----
// Decimal text to binary64 parser: character parsing and conversion sequencer.
// Depends on dtd_pkg.
`timescale 1ns / 1ps
//
//   port group | dir | word
//   req_       | in  | one character, last flag
//   rsp_       | out | binary64 bits, fallback flag
//
// A character that is not last leaves the parser ready for the next character.
// A last character starts the sequencer: integer normalize and round,
// fraction long division and round, alignment shift, add and final step;
// req_stall is high until it returns to idle. With 24 or more integer digits
// it goes straight to the final step with the fallback flag set.
// Synchronous reset returns to the start of a string with no word pending.
// rsp_stall holds the result register; the sequencer waits in its last step.

module decimal_text_to_double #(
   parameter int FRACTION_DIGITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dtd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dtd_pkg::rsp_type rsp_data
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_INORM  = 4'd1;
   localparam logic [3:0] S_IROUND = 4'd2;
   localparam logic [3:0] S_FDIV   = 4'd3;
   localparam logic [3:0] S_FROUND = 4'd4;
   localparam logic [3:0] S_ALIGN  = 4'd5;
   localparam logic [3:0] S_SHIFT  = 4'd6;
   localparam logic [3:0] S_ADD    = 4'd7;
   localparam logic [3:0] S_FINAL  = 4'd8;

   localparam logic [3:0] FRAC_MAX = 4'(FRACTION_DIGITS);
   localparam logic [5:0] Q_BITS   = 6'd56;

   logic [3:0]        state_ff;
   logic [1:0]        phase_ff, phase_in;
   logic              neg_ff, neg_in;
   logic [63:0]       iacc_ff, iacc_in;
   logic [4:0]        icnt_ff, icnt_in;
   logic [26:0]       facc_ff, facc_in;
   logic [3:0]        fcnt_ff, fcnt_in;
   logic              fb_ff, zero_ff, azero_ff, bzero_ff, found_ff;
   logic signed [7:0] exp_ff, aexp_ff, bexp_ff;
   logic [55:0]       w_ff, ysh_ff;
   logic [52:0]       amant_ff, bmant_ff;
   logic [26:0]       pow_ff;
   logic [5:0]        qcnt_ff;
   logic [7:0]        dcnt_ff;
   logic              rsp_valid_ff;
   dtd_pkg::rsp_type  rsp_data_ff;

   logic              accept, is_digit;
   logic [3:0]        dval;
   logic [1:0]        eff_phase;
   logic [27:0]       r2;
   logic              ge;
   logic [27:0]       rdiff;
   logic [56:0]       sum;
   dtd_pkg::rnd_type  rnd;
   logic [10:0]       biased;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign is_digit  = (req_data.text_char >= dtd_pkg::CH_ZERO) &&
                      (req_data.text_char <= dtd_pkg::CH_NINE);
   assign dval      = req_data.text_char[3:0];
   assign eff_phase = (phase_ff == dtd_pkg::PH_START) ? dtd_pkg::PH_INT : phase_ff;

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      iacc_in  = iacc_ff;
      icnt_in  = icnt_ff;
      facc_in  = facc_ff;
      fcnt_in  = fcnt_ff;
      if (phase_ff == dtd_pkg::PH_START &&
          (req_data.text_char == dtd_pkg::CH_MINUS ||
           req_data.text_char == dtd_pkg::CH_PLUS)) begin
         phase_in = dtd_pkg::PH_INT;
         neg_in   = (req_data.text_char == dtd_pkg::CH_MINUS);
      end else begin
         case (eff_phase)
            dtd_pkg::PH_INT: begin
               phase_in = dtd_pkg::PH_INT;
               if (is_digit) begin
                  iacc_in = (iacc_ff << 3) + (iacc_ff << 1) + {60'd0, dval};
                  if (icnt_ff < dtd_pkg::INT_LIMIT) icnt_in = icnt_ff + 5'd1;
               end else if (req_data.text_char == dtd_pkg::CH_DOT) begin
                  phase_in = dtd_pkg::PH_FRAC;
               end else begin
                  phase_in = dtd_pkg::PH_STOP;
               end
            end
            dtd_pkg::PH_FRAC: begin
               if (is_digit) begin
                  if (fcnt_ff < FRAC_MAX) begin
                     facc_in = (facc_ff << 3) + (facc_ff << 1) + {23'd0, dval};
                     fcnt_in = fcnt_ff + 4'd1;
                  end
               end else begin
                  phase_in = dtd_pkg::PH_STOP;
               end
            end
            default: ;
         endcase
      end
   end

   assign r2    = {facc_ff, 1'b0};
   assign ge    = r2 >= {1'b0, pow_ff};
   assign rdiff = r2 - {1'b0, pow_ff};
   assign sum   = {1'b0, w_ff} + {1'b0, ysh_ff};
   assign rnd   = dtd_pkg::round_ne(w_ff, exp_ff);
   assign biased = {{3{rnd.expo[7]}}, rnd.expo} + dtd_pkg::EXP_BIAS;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= dtd_pkg::PH_START;
         neg_ff       <= 1'b0;
         iacc_ff      <= '0;
         icnt_ff      <= '0;
         facc_ff      <= '0;
         fcnt_ff      <= '0;
         fb_ff        <= 1'b0;
         zero_ff      <= 1'b0;
         azero_ff     <= 1'b0;
         bzero_ff     <= 1'b0;
         found_ff     <= 1'b0;
         qcnt_ff      <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_FINAL) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  phase_ff <= phase_in;
                  neg_ff   <= neg_in;
                  iacc_ff  <= iacc_in;
                  icnt_ff  <= icnt_in;
                  facc_ff  <= facc_in;
                  fcnt_ff  <= fcnt_in;
                  if (req_data.is_last) begin
                     fb_ff    <= (icnt_in >= dtd_pkg::INT_LIMIT);
                     zero_ff  <= 1'b0;
                     azero_ff <= 1'b0;
                     bzero_ff <= 1'b0;
                     exp_ff   <= 8'sd63;
                     state_ff <= (icnt_in >= dtd_pkg::INT_LIMIT) ? S_FINAL : S_INORM;
                  end
               end
            end
            S_INORM: begin
               if (iacc_ff == 64'd0) begin
                  azero_ff <= 1'b1;
                  state_ff <= S_IROUND;
               end else if (iacc_ff[63]) begin
                  w_ff     <= {iacc_ff[63:9], |iacc_ff[8:0]};
                  state_ff <= S_IROUND;
               end else begin
                  iacc_ff <= {iacc_ff[62:0], 1'b0};
                  exp_ff  <= exp_ff - 8'sd1;
               end
            end
            S_IROUND: begin
               amant_ff <= rnd.mant;
               aexp_ff  <= rnd.expo;
               pow_ff   <= dtd_pkg::pow10(fcnt_ff);
               exp_ff   <= 8'sd0;
               qcnt_ff  <= '0;
               found_ff <= 1'b0;
               w_ff     <= '0;
               if (fcnt_ff == 4'd0 || facc_ff == 27'd0) begin
                  bzero_ff <= 1'b1;
                  state_ff <= S_ALIGN;
               end else begin
                  state_ff <= S_FDIV;
               end
            end
            S_FDIV: begin
               if (qcnt_ff == Q_BITS) begin
                  w_ff     <= {w_ff[55:1], w_ff[0] | (facc_ff != 27'd0)};
                  state_ff <= S_FROUND;
               end else begin
                  facc_ff <= ge ? rdiff[26:0] : r2[26:0];
                  if (!found_ff) begin
                     exp_ff <= exp_ff - 8'sd1;
                     if (ge) begin
                        found_ff <= 1'b1;
                        w_ff     <= {w_ff[54:0], 1'b1};
                        qcnt_ff  <= 6'd1;
                     end
                  end else begin
                     w_ff    <= {w_ff[54:0], ge};
                     qcnt_ff <= qcnt_ff + 6'd1;
                  end
               end
            end
            S_FROUND: begin
               bmant_ff <= rnd.mant;
               bexp_ff  <= rnd.expo;
               state_ff <= S_ALIGN;
            end
            S_ALIGN: begin
               if (azero_ff && bzero_ff) begin
                  zero_ff  <= 1'b1;
                  state_ff <= S_FINAL;
               end else if (bzero_ff) begin
                  w_ff     <= {amant_ff, 3'b000};
                  exp_ff   <= aexp_ff;
                  state_ff <= S_FINAL;
               end else if (azero_ff) begin
                  w_ff     <= {bmant_ff, 3'b000};
                  exp_ff   <= bexp_ff;
                  state_ff <= S_FINAL;
               end else begin
                  w_ff     <= {amant_ff, 3'b000};
                  ysh_ff   <= {bmant_ff, 3'b000};
                  exp_ff   <= aexp_ff;
                  dcnt_ff  <= 8'(aexp_ff - bexp_ff);
                  state_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               if (dcnt_ff == 8'd0 || ysh_ff == 56'd0) begin
                  state_ff <= S_ADD;
               end else begin
                  ysh_ff  <= {1'b0, ysh_ff[55:2], ysh_ff[1] | ysh_ff[0]};
                  dcnt_ff <= dcnt_ff - 8'd1;
               end
            end
            S_ADD: begin
               if (sum[56]) begin
                  w_ff   <= {sum[56:2], sum[1] | sum[0]};
                  exp_ff <= exp_ff + 8'sd1;
               end else begin
                  w_ff <= sum[55:0];
               end
               state_ff <= S_FINAL;
            end
            S_FINAL: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff.needs_fallback <= fb_ff;
                  if (fb_ff) rsp_data_ff.value_bits <= 64'd0;
                  else if (zero_ff) rsp_data_ff.value_bits <= {neg_ff, 63'd0};
                  else rsp_data_ff.value_bits <= {neg_ff, biased, rnd.mant[51:0]};
                  phase_ff <= dtd_pkg::PH_START;
                  neg_ff   <= 1'b0;
                  iacc_ff  <= '0;
                  icnt_ff  <= '0;
                  facc_ff  <= '0;
                  fcnt_ff  <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- hdl/dtd_checker.sv -----
// Port-level checks for decimal_text_to_double, bound into that module.
// Depends on dtd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtd_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input dtd_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dtd_pkg::rsp_type rsp_data
);

   `ASSERT_NEXT(rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(rsp_data_hold, rsp_valid && rsp_stall, $stable(rsp_data))
   `ASSERT_IMPL(fallback_zero, rsp_valid && rsp_data.needs_fallback, rsp_data.value_bits == 64'd0)
   `ASSERT_ALWAYS(reset_clears, $past(reset), !rsp_valid)
   `ASSERT_NEXT(busy_after_last, req_valid && !req_stall && req_data.is_last, req_stall)

endmodule

bind decimal_text_to_double dtd_checker u_dtd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
